>>> hdl/rrt_pkg.sv
// Shared types and constants for the 3D region traversal block.
// Used by rrt_div and ray_region_traversal_3d; depends on nothing else.
package rrt_pkg;

   typedef struct packed {
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] start_z;
      logic signed [31:0] end_x;
      logic signed [31:0] end_y;
      logic signed [31:0] end_z;
   } rrt_req_type;

   typedef struct packed {
      logic signed [15:0] key_x;
      logic signed [15:0] key_y;
      logic signed [15:0] key_z;
      logic               last;
      logic               truncated;
   } rrt_rsp_type;

   typedef struct packed {
      logic        start;
      logic [33:0] rem_init;
      logic [47:0] low;
      logic [5:0]  iters;
      logic [33:0] den;
   } rrt_div_req_type;

   typedef struct packed {
      logic        done;
      logic        ovf;
      logic        rem_nz;
      logic [47:0] quot;
   } rrt_div_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_KEY_START,
      ST_KEY_WAIT,
      ST_LEN_MUL,
      ST_LEN_ACC,
      ST_DECIDE,
      ST_SHORT2,
      ST_AX_START,
      ST_DL_WAIT,
      ST_TM_START,
      ST_TM_WAIT,
      ST_WALK
   } rrt_state_type;

   localparam logic [1:0] CSR_SIZE_X = 2'd0;
   localparam logic [1:0] CSR_SIZE_Y = 2'd1;
   localparam logic [1:0] CSR_SIZE_Z = 2'd2;
   localparam logic [1:0] CSR_RES    = 2'd3;

   localparam logic [30:0] SIZE_RESET = 31'd655360;
   localparam logic [30:0] RES_RESET  = 31'd6554;

   localparam logic [47:0]        TMAX      = 48'hFFFF_FFFF_FFFF;
   localparam logic [48:0]        T_ONE     = 49'h1_0000_0000;
   localparam logic [5:0]         KEY_ITERS = 6'd17;
   localparam logic [5:0]         Q32_ITERS = 6'd48;
   localparam logic signed [15:0] KEY_MAX   = 16'sh7FFF;
   localparam logic signed [15:0] KEY_MIN   = 16'sh8000;

endpackage

>>> hdl/rrt_div.sv
// Restoring divider, one quotient bit per cycle, shared by the key and time setup.
// Depends on rrt_pkg for its request and response types.
module rrt_div (
   input  logic                     clock,
   input  logic                     reset,
   input  rrt_pkg::rrt_div_req_type div_req,
   output rrt_pkg::rrt_div_rsp_type div_rsp
);

   logic [33:0] rem_ff, rem_in;
   logic [47:0] sh_ff, sh_in;
   logic [47:0] q_ff, q_in;
   logic [33:0] den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        ovf_ff, ovf_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [34:0] trial;
   logic [34:0] diff;
   logic        ge;

   always_comb begin
      trial   = {rem_ff, sh_ff[47]};
      ge      = trial >= {1'b0, den_ff};
      diff    = trial - {1'b0, den_ff};
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      ovf_in  = ovf_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = div_req.rem_init;
         sh_in   = div_req.low;
         q_in    = '0;
         den_in  = div_req.den;
         cnt_in  = div_req.iters;
         ovf_in  = div_req.rem_init >= div_req.den;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[33:0] : trial[33:0];
         q_in   = {q_ff[46:0], ge};
         sh_in  = {sh_ff[46:0], 1'b0};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      q_ff   <= q_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      ovf_ff <= ovf_in;
   end

   assign div_rsp.done   = done_ff;
   assign div_rsp.ovf    = ovf_ff;
   assign div_rsp.rem_nz = rem_ff != '0;
   assign div_rsp.quot   = q_ff;

endmodule

>>> hdl/ray_region_traversal_3d.sv
// Top level of the 3D region traversal: sequencer, registers and walk datapath.
// Depends on rrt_pkg and instantiates rrt_div.
//
//   Channel | Ports                            | Direction
//   --------+----------------------------------+-------------------------------
//   request | req_valid, req_stall, req_data   | segment in
//   result  | rsp_valid, rsp_stall, rsp_data   | region keys out, last flagged
//   csr     | csr_valid, csr_ready, csr_index, | register writes
//           | csr_wdata                        |
//
// Setup runs the bit-serial divider: six 17-step key divisions and two 48-step divisions
// per moving axis. The walk then emits one key per cycle while the result is not
// stalled. Reset is synchronous and restores the register defaults. A new request is
// taken only in idle; a stalled result holds the walk until the output register frees.
module ray_region_traversal_3d #(
   parameter int MAX_REGIONS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  rrt_pkg::rrt_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rrt_pkg::rrt_rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [30:0]          csr_wdata
);

   localparam int CW = $clog2(MAX_REGIONS + 1);

   rrt_pkg::rrt_state_type state_ff, state_in;

   logic [30:0]        size_ff [3];
   logic [30:0]        res_ff;
   logic [2:0]         idx_ff, idx_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic signed [31:0] s_ff [3];
   logic signed [31:0] e_ff [3];
   logic signed [32:0] d_ff [3];
   logic signed [15:0] cur_ff [3], cur_in [3];
   logic signed [15:0] endk_ff [3], endk_in [3];
   logic signed [48:0] tm_ff [3], tm_in [3];
   logic [47:0]        dl_ff [3], dl_in [3];
   logic [63:0]        len_ff, len_in;
   logic               short_ff, short_in;
   logic               key_neg_ff, key_neg_in;
   logic               tneg_ff, tneg_in;
   logic               reached_ff, reached_in;
   logic signed [50:0] num_ff;
   logic signed [65:0] prod_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rrt_pkg::rrt_rsp_type rsp_data_ff, rsp_data_in;

   rrt_pkg::rrt_div_req_type div_req;
   rrt_pkg::rrt_div_rsp_type div_rsp;

   logic [30:0]        sz [3];
   logic [31:0]        absd [3];
   logic [1:0]         ax_i;
   logic [1:0]         kax;
   logic signed [31:0] kp;
   logic [33:0]        keyn;
   logic [33:0]        kmag;
   logic [17:0]        tmul_a;
   logic signed [32:0] mul_a, mul_b;
   logic [49:0]        anum;
   logic [16:0]        q17;
   logic [17:0]        m18;
   logic signed [15:0] keyv;
   logic [47:0]        qs;
   logic [48:0]        tm_res;
   logic [64:0]        lsum;
   logic [70:0]        len100;
   logic               same_cur;
   logic               emit_ok;
   logic               walk_done;
   logic               walk_trunc;
   logic [1:0]         sel_ax;
   logic [48:0]        tabs;
   logic signed [49:0] tsum;
   logic               moving;

   rrt_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sz[i]   = (size_ff[i] == '0) ? 31'd1 : size_ff[i];
         absd[i] = d_ff[i][32] ? 32'(-d_ff[i]) : d_ff[i][31:0];
      end
      ax_i     = idx_ff[1:0];
      moving   = d_ff[ax_i] != '0;
      kax      = (idx_ff < 3'd3) ? idx_ff[1:0] : 2'(idx_ff - 3'd3);
      kp       = (idx_ff < 3'd3) ? s_ff[kax] : e_ff[kax];
      keyn     = {kp[31], kp, 1'b0} + {3'b0, sz[kax]};
      kmag     = keyn[33] ? 34'(-keyn) : keyn;
      tmul_a   = 18'({{2{cur_ff[ax_i][15]}}, cur_ff[ax_i]} <<< 1)
                 + (d_ff[ax_i][32] ? 18'h3FFFF : 18'd1);
      anum     = num_ff[50] ? 50'(-num_ff) : num_ff[49:0];
      same_cur = (cur_ff[0] == endk_ff[0]) && (cur_ff[1] == endk_ff[1])
                 && (cur_ff[2] == endk_ff[2]);
      emit_ok  = !rsp_valid_ff || !rsp_stall;
      walk_done  = reached_ff || same_cur;
      walk_trunc = cnt_ff == CW'(MAX_REGIONS - 1);
      if (tm_ff[0] < tm_ff[2]) begin
         sel_ax = (tm_ff[0] < tm_ff[1]) ? 2'd0 : 2'd1;
      end else begin
         sel_ax = (tm_ff[1] < tm_ff[2]) ? 2'd1 : 2'd2;
      end
      tabs = tm_ff[sel_ax][48] ? 49'(-tm_ff[sel_ax]) : tm_ff[sel_ax];
      tsum = {tm_ff[sel_ax][48], tm_ff[sel_ax]} + $signed({2'b0, dl_ff[sel_ax]});
   end

   always_comb begin
      if (state_ff == rrt_pkg::ST_LEN_MUL || state_ff == rrt_pkg::ST_LEN_ACC) begin
         if (idx_ff == 3'd3) begin
            mul_a = $signed({2'b0, res_ff});
         end else begin
            mul_a = $signed({1'b0, absd[ax_i]});
         end
         mul_b = mul_a;
      end else begin
         mul_a = $signed({{15{tmul_a[17]}}, tmul_a});
         mul_b = $signed({2'b0, sz[ax_i]});
      end
   end

   always_comb begin
      div_req = '0;
      unique case (state_ff)
         rrt_pkg::ST_KEY_START: begin
            div_req.start    = 1'b1;
            div_req.rem_init = {17'b0, kmag[33:17]};
            div_req.low      = {kmag[16:0], 31'b0};
            div_req.iters    = rrt_pkg::KEY_ITERS;
            div_req.den      = {2'b0, sz[kax], 1'b0};
         end
         rrt_pkg::ST_AX_START: begin
            div_req.start    = moving;
            div_req.rem_init = {19'b0, sz[ax_i][30:16]};
            div_req.low      = {sz[ax_i][15:0], 32'b0};
            div_req.iters    = rrt_pkg::Q32_ITERS;
            div_req.den      = {2'b0, absd[ax_i]};
         end
         rrt_pkg::ST_TM_START: begin
            div_req.start    = 1'b1;
            div_req.rem_init = anum[49:16];
            div_req.low      = {anum[15:0], 32'b0};
            div_req.iters    = rrt_pkg::Q32_ITERS;
            div_req.den      = {1'b0, absd[ax_i], 1'b0};
         end
         default: div_req = '0;
      endcase
   end

   always_comb begin
      q17 = div_rsp.quot[16:0];
      m18 = {1'b0, q17} + {17'b0, div_rsp.rem_nz};
      if (div_rsp.ovf) begin
         keyv = key_neg_ff ? rrt_pkg::KEY_MIN : rrt_pkg::KEY_MAX;
      end else if (!key_neg_ff) begin
         keyv = (q17 > 17'd32767) ? rrt_pkg::KEY_MAX : $signed(q17[15:0]);
      end else begin
         keyv = (m18 > 18'd32768) ? rrt_pkg::KEY_MIN : $signed(16'(~m18 + 18'd1));
      end
      qs     = div_rsp.ovf ? rrt_pkg::TMAX : div_rsp.quot;
      tm_res = tneg_ff ? 49'(-{1'b0, qs}) : {1'b0, qs};
      lsum   = {1'b0, len_ff} + {1'b0, prod_ff[63:0]};
      len100 = {1'b0, len_ff, 6'b0} + {2'b0, len_ff, 5'b0} + {5'b0, len_ff, 2'b0};
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rrt_pkg::ST_IDLE:      if (req_valid) state_in = rrt_pkg::ST_KEY_START;
         rrt_pkg::ST_KEY_START: state_in = rrt_pkg::ST_KEY_WAIT;
         rrt_pkg::ST_KEY_WAIT: begin
            if (div_rsp.done) begin
               state_in = (idx_ff == 3'd5) ? rrt_pkg::ST_LEN_MUL : rrt_pkg::ST_KEY_START;
            end
         end
         rrt_pkg::ST_LEN_MUL:   state_in = rrt_pkg::ST_LEN_ACC;
         rrt_pkg::ST_LEN_ACC: begin
            state_in = (idx_ff == 3'd3) ? rrt_pkg::ST_DECIDE : rrt_pkg::ST_LEN_MUL;
         end
         rrt_pkg::ST_DECIDE: begin
            if (!same_cur && !short_ff) begin
               state_in = rrt_pkg::ST_AX_START;
            end else if (emit_ok) begin
               state_in = same_cur ? rrt_pkg::ST_IDLE : rrt_pkg::ST_SHORT2;
            end
         end
         rrt_pkg::ST_SHORT2:    if (emit_ok) state_in = rrt_pkg::ST_IDLE;
         rrt_pkg::ST_AX_START: begin
            if (moving) begin
               state_in = rrt_pkg::ST_DL_WAIT;
            end else if (idx_ff == 3'd2) begin
               state_in = rrt_pkg::ST_WALK;
            end
         end
         rrt_pkg::ST_DL_WAIT:   if (div_rsp.done) state_in = rrt_pkg::ST_TM_START;
         rrt_pkg::ST_TM_START:  state_in = rrt_pkg::ST_TM_WAIT;
         rrt_pkg::ST_TM_WAIT: begin
            if (div_rsp.done) begin
               state_in = (idx_ff == 3'd2) ? rrt_pkg::ST_WALK : rrt_pkg::ST_AX_START;
            end
         end
         rrt_pkg::ST_WALK: begin
            if (emit_ok && (walk_done || walk_trunc)) state_in = rrt_pkg::ST_IDLE;
         end
         default: state_in = rrt_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      idx_in      = idx_ff;
      cnt_in      = cnt_ff;
      cur_in      = cur_ff;
      endk_in     = endk_ff;
      tm_in       = tm_ff;
      dl_in       = dl_ff;
      len_in      = len_ff;
      short_in    = short_ff;
      key_neg_in  = key_neg_ff;
      tneg_in     = tneg_ff;
      reached_in  = reached_ff;
      rsp_valid_in = rsp_stall ? rsp_valid_ff : 1'b0;
      rsp_data_in = rsp_data_ff;
      unique case (state_ff)
         rrt_pkg::ST_IDLE: begin
            idx_in     = '0;
            cnt_in     = '0;
            len_in     = '0;
            reached_in = 1'b0;
         end
         rrt_pkg::ST_KEY_START: key_neg_in = keyn[33];
         rrt_pkg::ST_KEY_WAIT: begin
            if (div_rsp.done) begin
               if (idx_ff < 3'd3) begin
                  cur_in[kax] = keyv;
               end else begin
                  endk_in[kax] = keyv;
               end
               idx_in = (idx_ff == 3'd5) ? 3'd0 : idx_ff + 3'd1;
            end
         end
         rrt_pkg::ST_LEN_ACC: begin
            if (idx_ff == 3'd3) begin
               short_in = len100 < {9'b0, prod_ff[61:0]};
               idx_in   = '0;
            end else begin
               len_in = lsum[64] ? '1 : lsum[63:0];
               idx_in = idx_ff + 3'd1;
            end
         end
         rrt_pkg::ST_DECIDE: begin
            if ((same_cur || short_ff) && emit_ok) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{cur_ff[0], cur_ff[1], cur_ff[2], same_cur, 1'b0};
            end
         end
         rrt_pkg::ST_SHORT2: begin
            if (emit_ok) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{endk_ff[0], endk_ff[1], endk_ff[2], 1'b1, 1'b0};
            end
         end
         rrt_pkg::ST_AX_START: begin
            if (!moving) begin
               tm_in[ax_i] = {1'b0, rrt_pkg::TMAX};
               dl_in[ax_i] = rrt_pkg::TMAX;
               idx_in      = idx_ff + 3'd1;
            end
         end
         rrt_pkg::ST_DL_WAIT: if (div_rsp.done) dl_in[ax_i] = qs;
         rrt_pkg::ST_TM_START: tneg_in = num_ff[50] != d_ff[ax_i][32];
         rrt_pkg::ST_TM_WAIT: begin
            if (div_rsp.done) begin
               tm_in[ax_i] = tm_res;
               idx_in      = idx_ff + 3'd1;
            end
         end
         rrt_pkg::ST_WALK: begin
            if (emit_ok) begin
               rsp_valid_in = 1'b1;
               if (walk_done) begin
                  rsp_data_in = '{cur_ff[0], cur_ff[1], cur_ff[2], 1'b1, 1'b0};
               end else begin
                  rsp_data_in = '{cur_ff[0], cur_ff[1], cur_ff[2], walk_trunc, walk_trunc};
                  reached_in  = (d_ff[sel_ax] != '0) ? (tabs > rrt_pkg::T_ONE)
                                                     : (tabs != '0);
                  if (d_ff[sel_ax] != '0) begin
                     cur_in[sel_ax] = cur_ff[sel_ax] + (d_ff[sel_ax][32] ? -16'sd1 : 16'sd1);
                  end
                  tm_in[sel_ax] = (tsum > $signed({2'b0, rrt_pkg::TMAX}))
                                  ? {1'b0, rrt_pkg::TMAX} : tsum[48:0];
                  cnt_in = cnt_ff + CW'(1);
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rrt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         size_ff[0]   <= rrt_pkg::SIZE_RESET;
         size_ff[1]   <= rrt_pkg::SIZE_RESET;
         size_ff[2]   <= rrt_pkg::SIZE_RESET;
         res_ff       <= rrt_pkg::RES_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         if (csr_valid) begin
            unique case (csr_index)
               rrt_pkg::CSR_SIZE_X: size_ff[0] <= csr_wdata;
               rrt_pkg::CSR_SIZE_Y: size_ff[1] <= csr_wdata;
               rrt_pkg::CSR_SIZE_Z: size_ff[2] <= csr_wdata;
               rrt_pkg::CSR_RES:    res_ff     <= csr_wdata;
               default: ;
            endcase
         end
      end
      if (state_ff == rrt_pkg::ST_IDLE && req_valid) begin
         s_ff[0] <= req_data.start_x;
         s_ff[1] <= req_data.start_y;
         s_ff[2] <= req_data.start_z;
         e_ff[0] <= req_data.end_x;
         e_ff[1] <= req_data.end_y;
         e_ff[2] <= req_data.end_z;
         d_ff[0] <= 33'(req_data.end_x) - 33'(req_data.start_x);
         d_ff[1] <= 33'(req_data.end_y) - 33'(req_data.start_y);
         d_ff[2] <= 33'(req_data.end_z) - 33'(req_data.start_z);
      end
      cur_ff      <= cur_in;
      endk_ff     <= endk_in;
      tm_ff       <= tm_in;
      dl_ff       <= dl_in;
      len_ff      <= len_in;
      short_ff    <= short_in;
      key_neg_ff  <= key_neg_in;
      tneg_ff     <= tneg_in;
      reached_ff  <= reached_in;
      rsp_data_ff <= rsp_data_in;
      prod_ff     <= mul_a * mul_b;
      num_ff      <= prod_ff[50:0] - {{18{s_ff[ax_i][31]}}, s_ff[ax_i], 1'b0};
   end

   assign req_stall = state_ff != rrt_pkg::ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

`ifndef SYNTH
   a_cnt_cap: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_REGIONS))
      else $error("result count ran past the cap");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == rrt_pkg::ST_KEY_WAIT || state_ff == rrt_pkg::ST_DL_WAIT
                        || state_ff == rrt_pkg::ST_TM_WAIT))
      else $error("divider finished outside a wait state");

   a_req_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff == rrt_pkg::ST_KEY_START)
      else $error("accepted request did not start key setup");
`endif

endmodule
